@@ rtl/pen_packet_homography_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// Pen packet homography mapper: shared macros
// Assertion helpers for the mapper and its divider; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PEN_PACKET_HOMOGRAPHY_MAPPER_DEFINES_SVH
`define PEN_PACKET_HOMOGRAPHY_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define PHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define PHM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PHM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/phm_pkg.sv @@
// ----------------------------------------------------------------------------
// Pen packet homography mapper package
// Shared widths, register indexes, packet constants and types.
// ----------------------------------------------------------------------------
package phm_pkg;

	// Coefficient width default
	localparam int COEF_WIDTH_DEF = 32;

	// Packet and result widths
	localparam int BYTE_W  = 8;
	localparam int RAW_W   = 16;
	localparam int POS_W   = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_H1_H2  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_H3_H4  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_H5_H6  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_H7_H8  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_H9     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_EN = 3'd5;

	// Packet constants
	localparam logic [BYTE_W-1:0] SENSOR_OK = 8'h03;
	localparam logic [BYTE_W-1:0] TIP_MASK  = 8'h01;
	localparam logic [BYTE_W-1:0] LIT_MASK  = 8'h04;
	localparam logic [BYTE_W-1:0] BIG_MASK  = 8'h08;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DIVX,
		ST_DIVY,
		ST_EMIT
	} phm_state_t;

	// Divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} phm_div_stat_t;

endpackage

@@ rtl/phm_intf.sv @@
// ----------------------------------------------------------------------------
// Pen packet homography mapper channels
// Packet input, position result and configuration write channels.
// ----------------------------------------------------------------------------

// Pen packet channel
interface phm_pkt_if;
	import phm_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] sensor_byte;
	logic [BYTE_W-1:0] x_low_byte;
	logic [BYTE_W-1:0] x_high_byte;
	logic [BYTE_W-1:0] y_low_byte;
	logic [BYTE_W-1:0] y_high_byte;
	logic [BYTE_W-1:0] button_byte;

	modport source (output valid, sensor_byte, x_low_byte, x_high_byte,
		y_low_byte, y_high_byte, button_byte, input ready);
	modport sink (input valid, sensor_byte, x_low_byte, x_high_byte,
		y_low_byte, y_high_byte, button_byte, output ready);
endinterface

// Position result channel
interface phm_res_if;
	import phm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic                    tip_pressed;
	logic                    little_pressed;
	logic                    big_pressed;
	logic                    was_mapped;

	modport source (output valid, pos_x, pos_y, tip_pressed, little_pressed, big_pressed,
		was_mapped, input ready);
	modport sink (input valid, pos_x, pos_y, tip_pressed, little_pressed, big_pressed,
		was_mapped, output ready);
endinterface

// Configuration write channel
interface phm_cfg_if;
	import phm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pen_packet_homography_mapper.sv @@
// A packet with a bad sensor byte is dropped in its accept cycle. Raw packets
// go from ST_EMIT into the result register; mapped packets pass ST_MUL,
// ST_CHECK, ST_DIVX, ST_DIVY and ST_EMIT, with the serial divider giving two
// quotients per packet. One packet at a time: a new one is taken only in ST_IDLE.
// Reset (async, active low) loads the identity matrix, calibration off, no fault.
// ----------------------------------------------------------------------------
// Pen packet homography mapper
// Decodes pen packets and maps raw coordinates through a projective matrix
// using one shared multiplier and one shared serial divider.
// ----------------------------------------------------------------------------
`include "pen_packet_homography_mapper_defines.svh"

module pen_packet_homography_mapper #(
	parameter int COEF_WIDTH = phm_pkg::COEF_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	phm_pkt_if.sink   pkt,
	phm_res_if.source res,
	phm_cfg_if.sink   cfg
);
	import phm_pkg::*;

	// Product, accumulator and numerator widths
	localparam int PW = COEF_WIDTH + RAW_W + 1;
	localparam int AW = COEF_WIDTH + RAW_W + 2;
	localparam int NW = COEF_WIDTH + RAW_W + 4;

	// Multiply steps
	localparam logic [2:0] STEP_H7   = 3'd0;
	localparam logic [2:0] STEP_H8   = 3'd1;
	localparam logic [2:0] STEP_H1   = 3'd2;
	localparam logic [2:0] STEP_H2   = 3'd3;
	localparam logic [2:0] STEP_H4   = 3'd4;
	localparam logic [2:0] STEP_H5   = 3'd5;
	localparam logic [2:0] STEP_DONE = 3'd6;

	phm_state_t state_q, state_d;

	// Coefficient registers
	logic signed [COEF_WIDTH-1:0] h1_q, h2_q, h3_q, h4_q, h5_q, h6_q, h7_q, h8_q, h9_q;
	logic                         cal_en_q;
	logic                         fault_q;

	// Packet registers
	logic [RAW_W-1:0] rx_q, ry_q;
	logic             left_q, middle_q, right_q;
	logic             mapped_q;

	// Datapath registers
	logic [2:0]              step_q;
	logic signed [PW-1:0]    prod_s1;
	logic [2:0]              prod_step_s1;
	logic                    prod_vld_s1;
	logic signed [AW-1:0]    s_q, nx_q, ny_q;
	logic signed [NW-1:0]    num_y_q;
	logic signed [POS_W-1:0] qx_q, qy_q;

	// Result register
	logic                    res_vld_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic                    tip_pressed_q, little_pressed_q, big_pressed_q, was_mapped_q;

	// Control
	logic                         accept;
	logic                         map_en;
	logic                         fault_set;
	logic                         out_load;
	logic                         div_start;
	logic signed [NW-1:0]         div_dividend;
	logic signed [NW-1:0]         div_divisor;
	logic signed [NW-1:0]         num_x;
	logic signed [NW-1:0]         num_y;
	logic signed [NW-1:0]         div_quot;
	phm_div_stat_t                div_stat;
	logic signed [COEF_WIDTH-1:0] mul_a;
	logic [RAW_W-1:0]             mul_raw;
	logic signed [PW-1:0]         mul_p;

	assign accept = pkt.valid && pkt.ready;
	assign map_en = cal_en_q && !fault_q;

	// Rounding numerators and doubled scale
	assign num_x       = (NW'(nx_q) <<< 1) + NW'(s_q);
	assign num_y       = (NW'(ny_q) <<< 1) + NW'(s_q);
	assign div_divisor = NW'(s_q) <<< 1;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d      = state_q;
		pkt.ready    = 1'b0;
		fault_set    = 1'b0;
		out_load     = 1'b0;
		div_start    = 1'b0;
		div_dividend = num_x;
		unique case (state_q)
			ST_IDLE: begin
				pkt.ready = 1'b1;
				if (pkt.valid && (pkt.sensor_byte == SENSOR_OK)) begin
					state_d = map_en ? ST_MUL : ST_EMIT;
				end
			end
			ST_MUL: begin
				if (step_q == STEP_DONE) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (s_q == '0) begin
					fault_set = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIVX;
				end
			end
			ST_DIVX: begin
				if (div_stat.done) begin
					div_start    = 1'b1;
					div_dividend = num_y_q;
					state_d      = ST_DIVY;
				end
			end
			ST_DIVY: begin
				if (div_stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!res_vld_q || res.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration writes; writing calibrate_enable clears the fault
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q     <= COEF_WIDTH'(1);
			h2_q     <= '0;
			h3_q     <= '0;
			h4_q     <= '0;
			h5_q     <= COEF_WIDTH'(1);
			h6_q     <= '0;
			h7_q     <= '0;
			h8_q     <= '0;
			h9_q     <= COEF_WIDTH'(1);
			cal_en_q <= 1'b0;
			fault_q  <= 1'b0;
		end else begin
			if (fault_set) begin
				fault_q <= 1'b1;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_H1_H2: begin
						h1_q <= cfg.data[COEF_WIDTH-1:0];
						h2_q <= cfg.data[POS_W +: COEF_WIDTH];
					end
					CFG_H3_H4: begin
						h3_q <= cfg.data[COEF_WIDTH-1:0];
						h4_q <= cfg.data[POS_W +: COEF_WIDTH];
					end
					CFG_H5_H6: begin
						h5_q <= cfg.data[COEF_WIDTH-1:0];
						h6_q <= cfg.data[POS_W +: COEF_WIDTH];
					end
					CFG_H7_H8: begin
						h7_q <= cfg.data[COEF_WIDTH-1:0];
						h8_q <= cfg.data[POS_W +: COEF_WIDTH];
					end
					CFG_H9: begin
						h9_q <= cfg.data[COEF_WIDTH-1:0];
					end
					CFG_CAL_EN: begin
						cal_en_q <= cfg.data[0];
						fault_q  <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Shared multiplier operand select
	always_comb begin
		case (step_q)
			STEP_H7: begin mul_a = h7_q; mul_raw = rx_q; end
			STEP_H8: begin mul_a = h8_q; mul_raw = ry_q; end
			STEP_H1: begin mul_a = h1_q; mul_raw = rx_q; end
			STEP_H2: begin mul_a = h2_q; mul_raw = ry_q; end
			STEP_H4: begin mul_a = h4_q; mul_raw = rx_q; end
			STEP_H5: begin mul_a = h5_q; mul_raw = ry_q; end
			default: begin mul_a = '0;   mul_raw = rx_q; end
		endcase
	end

	assign mul_p = PW'(mul_a) * $signed({1'b0, mul_raw});

	// Multiply step counter and product valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_H7;
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= (state_q == ST_MUL) && (step_q != STEP_DONE);
			if (accept) begin
				step_q <= STEP_H7;
			end else if ((state_q == ST_MUL) && (step_q != STEP_DONE)) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Capture packet, run products into the three sums
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_q     <= {pkt.x_high_byte, pkt.x_low_byte};
			ry_q     <= {pkt.y_high_byte, pkt.y_low_byte};
			left_q   <= (pkt.button_byte & TIP_MASK) == '0;
			middle_q <= (pkt.button_byte & LIT_MASK) != '0;
			right_q  <= (pkt.button_byte & BIG_MASK) != '0;
			mapped_q <= map_en;
			s_q      <= AW'(h9_q);
			nx_q     <= AW'(h3_q);
			ny_q     <= AW'(h6_q);
		end else if (prod_vld_s1) begin
			case (prod_step_s1) inside
				STEP_H7, STEP_H8: s_q  <= s_q + AW'(prod_s1);
				STEP_H1, STEP_H2: nx_q <= nx_q + AW'(prod_s1);
				default:          ny_q <= ny_q + AW'(prod_s1);
			endcase
		end
		prod_s1      <= mul_p;
		prod_step_s1 <= step_q;
		if (state_q == ST_CHECK) begin
			num_y_q <= num_y;
		end
		if ((state_q == ST_DIVX) && div_stat.done) begin
			qx_q <= POS_W'(div_quot);
		end
		if ((state_q == ST_DIVY) && div_stat.done) begin
			qy_q <= POS_W'(div_quot);
		end
	end

	phm_divider #(
		.WIDTH (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_load) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x_q          <= mapped_q ? qx_q : POS_W'(rx_q);
			pos_y_q          <= mapped_q ? qy_q : POS_W'(ry_q);
			tip_pressed_q    <= left_q;
			little_pressed_q <= middle_q;
			big_pressed_q    <= right_q;
			was_mapped_q     <= mapped_q;
		end
	end

	assign res.valid          = res_vld_q;
	assign res.pos_x          = pos_x_q;
	assign res.pos_y          = pos_y_q;
	assign res.tip_pressed    = tip_pressed_q;
	assign res.little_pressed = little_pressed_q;
	assign res.big_pressed    = big_pressed_q;
	assign res.was_mapped     = was_mapped_q;

	`PHM_ASSERT_IMP(a_fault_from_check, clk, arst_n, $rose(fault_q),
		$past(state_q == ST_CHECK), "fault set outside the scale check")
	`PHM_ASSERT_IMP(a_div_in_div_states, clk, arst_n, div_stat.busy,
		(state_q == ST_DIVX) || (state_q == ST_DIVY), "divider busy outside divide states")
	`PHM_ASSERT_IMP(a_word_from_emit, clk, arst_n, $rose(res_vld_q),
		$past(state_q == ST_EMIT), "result word loaded outside emit")
	`PHM_ASSERT_NXT(a_zero_scale_drop, clk, arst_n, (state_q == ST_CHECK) && (s_q == '0),
		(state_q == ST_IDLE) && fault_q, "zero scale did not drop the packet")

endmodule

@@ rtl/phm_divider.sv @@
// ----------------------------------------------------------------------------
// Pen packet homography mapper: serial signed divider
// Restoring division of magnitudes, one quotient bit per cycle, truncating
// toward zero.
// ----------------------------------------------------------------------------
`include "pen_packet_homography_mapper_defines.svh"

module phm_divider #(
	parameter int WIDTH = 52
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [WIDTH-1:0]   dividend,
	input  logic signed [WIDTH-1:0]   divisor,
	output phm_pkg::phm_div_stat_t    stat,
	output logic signed [WIDTH-1:0]   quotient
);
	import phm_pkg::*;

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH:0]   rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH-1:0] quot_q;

	logic [WIDTH-1:0] dvd_mag;
	logic [WIDTH-1:0] dvs_mag;
	logic [WIDTH:0]   rem_sh;
	logic [WIDTH+1:0] diff;
	logic             ge;
	logic [WIDTH-1:0] quo_nx;

	// Take magnitudes; unsigned negation covers the most negative value
	assign dvd_mag = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
	assign dvs_mag = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;

	// One restoring step
	assign rem_sh = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = ~diff[WIDTH+1];
	assign quo_nx = {quo_q[WIDTH-2:0], ge};

	// Control: busy over WIDTH steps, done pulse after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
				neg_q  <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the dividend in, collect quotient bits
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dvd_mag;
			den_q <= dvs_mag;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WIDTH:0] : rem_sh;
			quo_q <= quo_nx;
			if (cnt_q == '0) begin
				quot_q <= neg_q ? (~quo_nx + 1'b1) : quo_nx;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quot_q;

	`PHM_ASSERT_IMP(a_start_idle, clk, arst_n, start, !busy_q,
		"divider started while busy")
	`PHM_ASSERT_NXT(a_done_pulse, clk, arst_n, done_q, !done_q,
		"divider done held longer than one cycle")
	`PHM_ASSERT_NXT(a_last_step_done, clk, arst_n, busy_q && (cnt_q == '0),
		done_q && !busy_q, "divider did not finish after its last step")

endmodule

@@ sim/tb_pen_packet_homography_mapper.sv @@
// ----------------------------------------------------------------------------
// Pen packet homography mapper testbench
// Streams pen packets through the mapper under a series of calibration
// matrices and checks every position report against an in-bench predictor.
// Both channels stall at random, and two long result stalls fill the block.
// ----------------------------------------------------------------------------
module tb_pen_packet_homography_mapper;
	import phm_pkg::*;

	localparam int CW          = COEF_WIDTH_DEF;
	localparam int CLK_PER     = 8;
	localparam int RAND_ITEMS  = 1750;
	localparam int QUIET_CYC   = 2 * CW + 58 + 60;
	localparam int DRAIN_LIMIT = 50000;
	localparam int HOLD_CYC    = 500;
	localparam int MAX_REPORTS = 200;
	localparam longint TIMEOUT_CYC = 3000000;

	// Register indexes past the end of the map; writes to them are ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

	// Matrix styles used by the random phases
	typedef enum int {
		CAL_RAW,
		CAL_WIDE,
		CAL_SMALL,
		CAL_EXTREME,
		CAL_FAULT
	} cal_mix_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sensor;
		logic [BYTE_W-1:0] x_lo;
		logic [BYTE_W-1:0] x_hi;
		logic [BYTE_W-1:0] y_lo;
		logic [BYTE_W-1:0] y_hi;
		logic [BYTE_W-1:0] buttons;
	} pen_pkt_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic                    tip_pressed;
		logic                    little_pressed;
		logic                    big_pressed;
		logic                    was_mapped;
	} pos_report_t;

	logic clk = 1'b0;
	logic arst_n;

	phm_pkt_if pkt ();
	phm_res_if res ();
	phm_cfg_if cfg ();

	pen_packet_homography_mapper #(
		.COEF_WIDTH(CW)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pkt   (pkt),
		.res   (res),
		.cfg   (cfg)
	);

	// Calibration state as the block should hold it
	logic [63:0] mtx_h12, mtx_h34, mtx_h56, mtx_h78;
	logic [31:0] mtx_h9;
	logic        map_on;
	int          cal_writes;
	logic        fault_set;
	int          fault_gen;

	pen_pkt_t    pend_q[$];
	pos_report_t pos_q[$];

	logic src_gaps, snk_gaps, hold_kick;
	int   hold_left = 0;

	int n_pushed, n_accepted, n_rejected, n_faults;
	int n_checked, n_mapped, n_err, drain_err, n_phases;

	always begin
		#(CLK_PER / 2) clk = 1'b1;
		#(CLK_PER / 2) clk = 1'b0;
	end

	// Sign-extend the low CW bits of a 32-bit coefficient slot
	function automatic longint coef_val(input logic [31:0] slot);
		return longint'($signed(slot[CW-1:0]));
	endfunction

	// Work out the report for one accepted packet; returns 0 when it is dropped
	function automatic bit map_pen_packet(input pen_pkt_t p, output pos_report_t r);
		longint rx, ry, s, nx, ny, qx, qy;
		r = '0;
		if (p.sensor != SENSOR_OK) begin
			n_rejected++;
			return 1'b0;
		end
		rx = {p.x_hi, p.x_lo};
		ry = {p.y_hi, p.y_lo};
		r.tip_pressed    = (p.buttons & TIP_MASK) == '0;
		r.little_pressed = (p.buttons & LIT_MASK) != '0;
		r.big_pressed    = (p.buttons & BIG_MASK) != '0;
		if (map_on && !(fault_set && fault_gen == cal_writes)) begin
			s = coef_val(mtx_h78[63:32]) * ry + coef_val(mtx_h78[31:0]) * rx
				+ coef_val(mtx_h9);
			// zero scale: latch the fault and drop the packet
			if (s == 0) begin
				fault_set = 1'b1;
				fault_gen = cal_writes;
				n_faults++;
				return 1'b0;
			end
			nx = coef_val(mtx_h12[31:0]) * rx + coef_val(mtx_h12[63:32]) * ry
				+ coef_val(mtx_h34[31:0]);
			ny = coef_val(mtx_h34[63:32]) * rx + coef_val(mtx_h56[31:0]) * ry
				+ coef_val(mtx_h56[63:32]);
			qx = (nx * 2 + s) / (s * 2);
			qy = (ny * 2 + s) / (s * 2);
			r.pos_x = qx[31:0];
			r.pos_y = qy[31:0];
			r.was_mapped = 1'b1;
		end else begin
			r.pos_x = rx[31:0];
			r.pos_y = ry[31:0];
		end
		return 1'b1;
	endfunction

	function automatic void check_field(input string fname, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			n_err++;
			// cap the log on a badly broken block; the count keeps going
			if (n_err <= MAX_REPORTS)
				$error("%s: expected %0d, got %0d", fname, want_v, got_v);
		end
	endfunction

	function automatic pen_pkt_t mk_pkt(input logic [7:0] sensor, input logic [15:0] x,
			input logic [15:0] y, input logic [7:0] buttons);
		return {sensor, x[7:0], x[15:8], y[7:0], y[15:8], buttons};
	endfunction

	function automatic logic [63:0] rand64();
		return {32'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [31:0] small_coef();
		int v;
		v = int'($urandom_range(32)) - 16;
		return v;
	endfunction

	function automatic logic [31:0] extreme_coef();
		logic [31:0] picks [5];
		picks = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1};
		return picks[$urandom_range(4)];
	endfunction

	// Random packet; near_aim pulls raw x next to the value that zeroes the scale
	function automatic pen_pkt_t rand_packet(input bit near_aim, input logic [15:0] aim);
		logic [7:0]  sensor;
		logic [15:0] rx, ry;
		sensor = ($urandom_range(99) < 88) ? SENSOR_OK : 8'($urandom_range(255));
		rx = 16'($urandom);
		ry = 16'($urandom);
		case ($urandom_range(9))
			0: rx = 16'h0000;
			1: rx = 16'hFFFF;
			2: ry = 16'h0000;
			3: ry = 16'hFFFF;
			default: ;
		endcase
		if (near_aim)
			rx = 16'(aim + $urandom_range(4) - 2);
		return mk_pkt(sensor, rx, ry, 8'($urandom));
	endfunction

	task automatic queue_packet(input pen_pkt_t p);
		pend_q.push_back(p);
		n_pushed++;
	endtask

	// Write one register and mirror it once the word is taken
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_H1_H2: mtx_h12 = val;
			CFG_H3_H4: mtx_h34 = val;
			CFG_H5_H6: mtx_h56 = val;
			CFG_H7_H8: mtx_h78 = val;
			CFG_H9:    mtx_h9  = val[31:0];
			CFG_CAL_EN: begin
				map_on = val[0];
				cal_writes++;
			end
			default: ;
		endcase
	endtask

	task automatic load_matrix(input logic [63:0] h12, input logic [63:0] h34,
			input logic [63:0] h56, input logic [63:0] h78, input logic [63:0] h9,
			input logic [63:0] enable);
		write_reg(CFG_H1_H2, h12);
		write_reg(CFG_H3_H4, h34);
		write_reg(CFG_H5_H6, h56);
		write_reg(CFG_H7_H8, h78);
		write_reg(CFG_H9, h9);
		write_reg(CFG_CAL_EN, enable);
	endtask

	// Hold off until every packet is taken and every report is back, then let
	// a dropped packet still in the sequencer finish
	task automatic wait_idle();
		int spins;
		spins = 0;
		while ((n_accepted != n_pushed || pos_q.size() != 0) && spins < DRAIN_LIMIT) begin
			@(posedge clk);
			spins++;
		end
		if (spins >= DRAIN_LIMIT) begin
			$error("drain stuck: %0d packets unsent, %0d reports outstanding",
				n_pushed - n_accepted, pos_q.size());
			drain_err++;
			pos_q.delete();
		end
		repeat (QUIET_CYC) @(posedge clk);
		n_phases++;
	endtask

	// Packet driver: hold the word until taken, then advance to the next one
	always @(posedge clk) begin
		pen_pkt_t    nxt;
		pos_report_t rpt;
		if (!arst_n) begin
			pkt.valid <= 1'b0;
		end else begin
			if (pkt.valid && pkt.ready) begin
				if (map_pen_packet({pkt.sensor_byte, pkt.x_low_byte, pkt.x_high_byte,
						pkt.y_low_byte, pkt.y_high_byte, pkt.button_byte}, rpt))
					pos_q.push_back(rpt);
				n_accepted++;
			end
			if (!pkt.valid || pkt.ready) begin
				if (pend_q.size() != 0 && !(src_gaps && $urandom_range(99) < 8)) begin
					nxt = pend_q.pop_front();
					pkt.valid       <= 1'b1;
					pkt.sensor_byte <= nxt.sensor;
					pkt.x_low_byte  <= nxt.x_lo;
					pkt.x_high_byte <= nxt.x_hi;
					pkt.y_low_byte  <= nxt.y_lo;
					pkt.y_high_byte <= nxt.y_hi;
					pkt.button_byte <= nxt.buttons;
				end else begin
					pkt.valid <= 1'b0;
				end
			end
		end
	end

	// Long result stall, counted down on its own
	always @(posedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_kick)
			hold_left <= HOLD_CYC;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Report monitor: compare each taken word with the oldest expectation
	always @(posedge clk) begin
		pos_report_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (pos_q.size() == 0) begin
					n_err++;
					$error("report with nothing expected: pos_x %0d, pos_y %0d",
						res.pos_x, res.pos_y);
				end else begin
					want = pos_q.pop_front();
					n_checked++;
					if (want.was_mapped)
						n_mapped++;
					check_field("pos_x", want.pos_x, res.pos_x);
					check_field("pos_y", want.pos_y, res.pos_y);
					check_field("tip_pressed", want.tip_pressed, res.tip_pressed);
					check_field("little_pressed", want.little_pressed, res.little_pressed);
					check_field("big_pressed", want.big_pressed, res.big_pressed);
					check_field("was_mapped", want.was_mapped, res.was_mapped);
				end
			end
			res.ready <= (hold_left == 0) && !(snk_gaps && $urandom_range(99) < 8);
		end
	end

	initial begin
		#(TIMEOUT_CYC * CLK_PER);
		$display("Verification failed");
		$finish;
	end

	// Stimulus: directed cases, then random calibration phases
	initial begin
		cal_mix_t    mix;
		logic [15:0] aim;
		logic [31:0] h7;
		logic        gap_src;
		int          len;

		arst_n          = 1'b0;
		pkt.valid       = 1'b0;
		pkt.sensor_byte = '0;
		pkt.x_low_byte  = '0;
		pkt.x_high_byte = '0;
		pkt.y_low_byte  = '0;
		pkt.y_high_byte = '0;
		pkt.button_byte = '0;
		res.ready       = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = '0;
		cfg.data        = '0;
		src_gaps        = 1'b0;
		snk_gaps        = 1'b0;
		hold_kick       = 1'b0;
		mtx_h12 = 64'd1;
		mtx_h34 = 64'd0;
		mtx_h56 = 64'd1;
		mtx_h78 = 64'd0;
		mtx_h9  = 32'd1;
		map_on  = 1'b0;
		cal_writes = 0;
		fault_set  = 1'b0;
		fault_gen  = 0;
		n_pushed = 0; n_accepted = 0; n_rejected = 0; n_faults = 0;
		n_checked = 0; n_mapped = 0; n_err = 0; drain_err = 0; n_phases = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Raw mode out of reset: coordinate extremes, every button, bad sensors
		write_reg(CFG_UNMAPPED_LO, rand64());
		write_reg(CFG_UNMAPPED_HI, rand64());
		write_reg(CFG_CAL_EN, 64'hFFFF_FFFF_FFFF_FFFE);
		queue_packet(mk_pkt(SENSOR_OK, 16'h0000, 16'h0000, 8'h00));
		queue_packet(mk_pkt(SENSOR_OK, 16'hFFFF, 16'hFFFF, 8'hFF));
		queue_packet(mk_pkt(SENSOR_OK, 16'h00FF, 16'hFF00, 8'h01));
		queue_packet(mk_pkt(SENSOR_OK, 16'hFF00, 16'h00FF, 8'h04));
		queue_packet(mk_pkt(SENSOR_OK, 16'h8001, 16'h7FFE, 8'h08));
		queue_packet(mk_pkt(SENSOR_OK, 16'h1234, 16'h5678, 8'hF2));
		queue_packet(mk_pkt(8'h00, 16'h1111, 16'h2222, 8'h00));
		queue_packet(mk_pkt(8'hFF, 16'h3333, 16'h4444, 8'h00));
		queue_packet(mk_pkt(8'h02, 16'h5555, 16'h6666, 8'h00));
		queue_packet(mk_pkt(8'h83, 16'h7777, 16'h8888, 8'h00));
		wait_idle();

		// Identity matrix with junk in the unused upper data bits
		load_matrix(64'h0000_0000_0000_0001, 64'h0, 64'h0000_0000_0000_0001, 64'h0,
			64'hA5A5_0000_0000_0001, 64'h8000_0000_0000_0001);
		queue_packet(mk_pkt(SENSOR_OK, 16'h1234, 16'hABCD, 8'h0E));
		queue_packet(mk_pkt(SENSOR_OK, 16'hFFFF, 16'h0000, 8'h05));
		wait_idle();

		// Extreme coefficients: mapped results wrap to 32 bits
		load_matrix({32'h8000_0000, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h8000_0000},
			{32'h7FFF_FFFF, 32'h8000_0000}, 64'h0, 64'h1, 64'h1);
		queue_packet(mk_pkt(SENSOR_OK, 16'hFFFF, 16'hFFFF, 8'h00));
		queue_packet(mk_pkt(SENSOR_OK, 16'h0000, 16'h0000, 8'h0D));
		queue_packet(mk_pkt(SENSOR_OK, 16'hFFFF, 16'h0000, 8'h09));
		wait_idle();

		// Scale is rx - 100: positive, negative, then zero latches the fault
		load_matrix({32'h0, 32'd3}, {32'h0, 32'd7}, {32'hFFFF_FFFB, 32'd2},
			{32'h0, 32'd1}, 64'hFFFF_FF9C, 64'h1);
		queue_packet(mk_pkt(SENSOR_OK, 16'd200, 16'd10, 8'h00));
		queue_packet(mk_pkt(SENSOR_OK, 16'd50, 16'd3, 8'h04));
		queue_packet(mk_pkt(SENSOR_OK, 16'd100, 16'd9, 8'h00));
		queue_packet(mk_pkt(SENSOR_OK, 16'd200, 16'd10, 8'h08));
		wait_idle();

		// A coefficient write leaves the fault latched
		write_reg(CFG_H9, 64'h1);
		queue_packet(mk_pkt(SENSOR_OK, 16'd300, 16'd20, 8'h01));
		wait_idle();

		// Rewriting the enable clears it
		write_reg(CFG_CAL_EN, 64'h1);
		queue_packet(mk_pkt(SENSOR_OK, 16'd100, 16'd9, 8'h00));
		wait_idle();

		// Random phases, each under a fresh matrix
		while (n_pushed < RAND_ITEMS) begin
			mix = cal_mix_t'($urandom_range(CAL_FAULT));
			aim = 16'($urandom);
			case (mix)
				CAL_RAW:
					load_matrix(rand64(), rand64(), rand64(), rand64(), rand64(),
						{32'($urandom), 31'($urandom), 1'b0});
				CAL_WIDE:
					load_matrix(rand64(), rand64(), rand64(), rand64(), rand64(),
						{32'($urandom), 31'($urandom), 1'b1});
				CAL_SMALL:
					load_matrix({small_coef(), small_coef()}, {small_coef(), small_coef()},
						{small_coef(), small_coef()}, {small_coef(), small_coef()},
						{32'($urandom), small_coef()}, 64'h1);
				CAL_EXTREME:
					load_matrix({extreme_coef(), extreme_coef()},
						{extreme_coef(), extreme_coef()}, {extreme_coef(), extreme_coef()},
						{extreme_coef(), extreme_coef()}, {32'($urandom), extreme_coef()},
						64'h1);
				default: begin
					// scale crosses zero at rx == aim
					h7 = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
					load_matrix({small_coef(), small_coef()}, {small_coef(), small_coef()},
						{small_coef(), small_coef()}, {32'h0, h7},
						{32'h0, (h7 == 32'd1) ? -{16'h0, aim} : {16'h0, aim}}, 64'h1);
				end
			endcase
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, rand64());

			gap_src = ($urandom_range(3) != 0);
			len = $urandom_range(60, 12);
			// Stall the report side while packets keep coming
			if (n_phases == 8 || n_phases == 20) begin
				gap_src = 1'b0;
				len = 48;
				hold_kick <= 1'b1;
			end
			src_gaps <= gap_src;
			snk_gaps <= ($urandom_range(3) != 0);
			@(posedge clk);
			hold_kick <= 1'b0;

			for (int i = 0; i < len; i++) begin
				pen_pkt_t p;
				p = rand_packet(mix == CAL_FAULT && $urandom_range(1), aim);
				queue_packet(p);
			end
			wait_idle();
		end

		$display("Run: %0d packets in %0d phases, %0d with a bad sensor byte, %0d zero-scale faults",
			n_pushed, n_phases, n_rejected, n_faults);
		$display("Run: %0d reports checked, %0d through the matrix, two long report stalls",
			n_checked, n_mapped);
		if (n_err == 0 && drain_err == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/phm_pkg.sv
rtl/phm_intf.sv
rtl/phm_divider.sv
rtl/pen_packet_homography_mapper.sv
sim/tb_pen_packet_homography_mapper.sv
